### sv/keyed_record_table_macros.svh
// Assertion macros for the keyed record table.
// Used by keyed_record_table.sv; expects clk and rst in scope.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_record_table: assertion failed");

// Next-cycle implication, disabled during reset.
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_record_table: assertion failed");

`endif

### sv/krt_pkg.sv
// Shared constants and types for the keyed record table.
// No dependencies; used by krt_cell, krt_chain and keyed_record_table.
package krt_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W  = 3;
  localparam int KEY_W = 37;
  localparam int DEP_W = 8;
  localparam int SAL_W = 32;
  localparam int POS_W = 9;
  localparam int ST_W  = 3;

  localparam logic [KEY_W-1:0] KEY_MAX = 37'd99999999999;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DEP_W-1:0] dep;
    logic [SAL_W-1:0] sal;
  } rec_t;

  // Broadcast to every cell during a sweep; flags refer to the token's position.
  typedef struct packed {
    logic [OP_W-1:0] op;
    rec_t            req;
    logic            cur_valid;
    logic            pos_hit;
    logic            cur_is_count;
  } sweep_ctl_t;

  // Handed from one cell to the next along with the sweep token.
  typedef struct packed {
    logic tok;
    logic found;
    rec_t rec;
  } link_t;

endpackage

### sv/krt_cell.sv
// One table entry plus its stage of the sweep chain.
// Depends on krt_pkg.
module krt_cell (
  input  logic               clk,
  input  logic               rst,
  input  krt_pkg::sweep_ctl_t ctl,
  input  krt_pkg::link_t     link_in,
  input  krt_pkg::rec_t      next_entry,
  output krt_pkg::link_t     link_out,
  output krt_pkg::rec_t      entry
);

  logic          match;
  logic          hit;
  logic          shift;
  logic          load_new;
  logic          upd;
  krt_pkg::rec_t hit_rec;

  always_comb begin
    match    = link_in.tok && ctl.cur_valid && (entry.key == ctl.req.key);
    hit      = 1'b0;
    shift    = 1'b0;
    load_new = 1'b0;
    upd      = 1'b0;
    hit_rec  = entry;
    case (ctl.op)
      krt_pkg::OP_INSERT: begin
        hit = match;
        // every valid entry sits below count, so found is final here
        load_new = link_in.tok && ctl.cur_is_count && !link_in.found;
      end
      krt_pkg::OP_LOOKUP: begin
        hit = match;
      end
      krt_pkg::OP_UPDATE: begin
        hit         = match;
        upd         = match;
        hit_rec.dep = ctl.req.dep;
        hit_rec.sal = ctl.req.sal;
      end
      krt_pkg::OP_DELETE: begin
        hit = match;
        // neighbor above has not been swept yet, so it still holds its old word
        shift = link_in.tok && (link_in.found || match);
      end
      krt_pkg::OP_READ: begin
        hit = link_in.tok && ctl.cur_valid && ctl.pos_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      entry <= ctl.req;
    end else if (shift) begin
      entry <= next_entry;
    end else if (upd) begin
      entry <= hit_rec;
    end
  end

  always_ff @(posedge clk) begin
    link_out.rec <= hit ? hit_rec : link_in.rec;
    if (rst) begin
      link_out.tok   <= 1'b0;
      link_out.found <= 1'b0;
    end else begin
      link_out.tok   <= link_in.tok;
      link_out.found <= link_in.found || hit;
    end
  end

endmodule

### sv/krt_chain.sv
// Row of TABLE_DEPTH cells; the sweep token enters at cell 0 and exits at the tail.
// Depends on krt_pkg and krt_cell.
module krt_chain (
  input  logic                clk,
  input  logic                rst,
  input  logic                launch,
  input  krt_pkg::sweep_ctl_t ctl,
  output krt_pkg::link_t      tail
);

  krt_pkg::link_t links   [krt_pkg::TABLE_DEPTH+1];
  krt_pkg::rec_t  entries [krt_pkg::TABLE_DEPTH];

  assign links[0].tok   = launch;
  assign links[0].found = 1'b0;
  assign links[0].rec   = '0;

  for (genvar i = 0; i < krt_pkg::TABLE_DEPTH; i++) begin : g_cell
    krt_pkg::rec_t nxt;
    if (i < krt_pkg::TABLE_DEPTH - 1) begin : g_mid
      assign nxt = entries[i+1];
    end else begin : g_last
      // top cell has no neighbor; what it shifts in lies past the count
      assign nxt = entries[i];
    end
    krt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .link_in    (links[i]),
      .next_entry (nxt),
      .link_out   (links[i+1]),
      .entry      (entries[i])
    );
  end

  assign tail = links[krt_pkg::TABLE_DEPTH];

endmodule

### sv/keyed_record_table.sv
// Keyed record table: unsorted, compact table of records held in a cell chain.
// Command channel: a request is taken at a clock edge with start high and busy
// low; op, key, dependents, salary_cents and position are sampled there.
// Result channel: done is high for one cycle with status, key_out,
// dependents_out, salary_out and entry_count; the word must be taken then.
// A request that needs the table is swept through the chain: a token walks
// the chain one cell per cycle, comparing, shifting on delete, updating in
// place on update and appending on insert, and a finish state then forms the
// result. Requests answered without the table (table full on insert, empty on
// read, unknown op) skip the sweep and go straight to the finish state.
// One request is in flight at a time; busy stays high until the done cycle,
// in which a new request may already be taken.
// Reset (rst, synchronous) clears the entry count and control; entry
// contents are not cleared and are only read once written.
// Keys above 99999999999 saturate on entry.
// Depends on krt_pkg, krt_chain, krt_cell and keyed_record_table_macros.svh.
`include "keyed_record_table_macros.svh"

module keyed_record_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [krt_pkg::OP_W-1:0]    op,
  input  logic [krt_pkg::KEY_W-1:0]   key,
  input  logic [krt_pkg::DEP_W-1:0]   dependents,
  input  logic [krt_pkg::SAL_W-1:0]   salary_cents,
  input  logic [krt_pkg::POS_W-1:0]   position,
  output logic                        busy,
  output logic                        done,
  output logic [krt_pkg::ST_W-1:0]    status,
  output logic [krt_pkg::KEY_W-1:0]   key_out,
  output logic [krt_pkg::DEP_W-1:0]   dependents_out,
  output logic [krt_pkg::SAL_W-1:0]   salary_out,
  output logic [krt_pkg::CNT_W-1:0]   entry_count
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [krt_pkg::OP_W-1:0]  req_op;
  krt_pkg::rec_t             req;
  logic [krt_pkg::POS_W-1:0] req_pos;
  logic                      early;
  logic [krt_pkg::ST_W-1:0]  early_status;
  logic [krt_pkg::IDX_W-1:0] idx;
  logic                      launch;
  logic [krt_pkg::CNT_W-1:0] count;

  logic                      accept;
  logic [krt_pkg::KEY_W-1:0] key_sat;
  logic                      early_now;
  logic [krt_pkg::ST_W-1:0]  early_status_now;
  krt_pkg::sweep_ctl_t       ctl;
  krt_pkg::link_t            tail;
  logic                      rec_zero;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign key_sat = (key > krt_pkg::KEY_MAX) ? krt_pkg::KEY_MAX : key;
  assign entry_count = count;
  assign rec_zero = ({key_out, dependents_out, salary_out} == '0);

  always_comb begin
    early_now        = 1'b0;
    early_status_now = krt_pkg::ST_NOT_FOUND;
    if (op > krt_pkg::OP_READ) begin
      early_now = 1'b1;
    end else if (op == krt_pkg::OP_INSERT &&
                 count >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH)) begin
      early_now        = 1'b1;
      early_status_now = krt_pkg::ST_FULL;
    end else if (op == krt_pkg::OP_READ && count == '0) begin
      early_now        = 1'b1;
      early_status_now = krt_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    ctl.op           = req_op;
    ctl.req          = req;
    ctl.cur_valid    = krt_pkg::CNT_W'(idx) < count;
    ctl.pos_hit      = 32'(idx) == 32'(req_pos);
    ctl.cur_is_count = krt_pkg::CNT_W'(idx) == count;
  end

  krt_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .ctl    (ctl),
    .tail   (tail)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = early_now ? S_FINISH : S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (idx == krt_pkg::IDX_W'(krt_pkg::TABLE_DEPTH - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      idx    <= '0;
      count  <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && !early_now;
      done   <= (state == S_FINISH);
      if (accept) begin
        idx <= '0;
      end else if (state == S_SWEEP) begin
        idx <= idx + 1'b1;
      end
      if (state == S_FINISH && !early) begin
        if (req_op == krt_pkg::OP_INSERT && !tail.found) begin
          count <= count + 1'b1;
        end else if (req_op == krt_pkg::OP_DELETE && tail.found) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op       <= op;
      req.key      <= key_sat;
      req.dep      <= dependents;
      req.sal      <= salary_cents;
      req_pos      <= position;
      early        <= early_now;
      early_status <= early_status_now;
    end
  end

  // result word, formed in the finish cycle
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      if (early) begin
        status         <= early_status;
        key_out        <= '0;
        dependents_out <= '0;
        salary_out     <= '0;
      end else if (req_op == krt_pkg::OP_INSERT && !tail.found) begin
        status         <= krt_pkg::ST_OK;
        key_out        <= req.key;
        dependents_out <= req.dep;
        salary_out     <= req.sal;
      end else if (req_op == krt_pkg::OP_INSERT) begin
        status         <= krt_pkg::ST_DUPLICATE;
        key_out        <= '0;
        dependents_out <= '0;
        salary_out     <= '0;
      end else if (tail.found) begin
        status         <= krt_pkg::ST_OK;
        key_out        <= tail.rec.key;
        dependents_out <= tail.rec.dep;
        salary_out     <= tail.rec.sal;
      end else begin
        status         <= krt_pkg::ST_NOT_FOUND;
        key_out        <= '0;
        dependents_out <= '0;
        salary_out     <= '0;
      end
    end
  end

  `KRT_ASSERT_IMPL(a_done_idle, done, !busy)
  `KRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `KRT_ASSERT_IMPL(a_count_bound, 1'b1, 32'(entry_count) <= 32'(krt_pkg::TABLE_DEPTH))
  `KRT_ASSERT_IMPL(a_fail_zero, done && status != krt_pkg::ST_OK, rec_zero)

endmodule
